[rtl/efsc_pkg.sv]
// efsc_pkg: shared types and constants of the escaped frame serial codec
// item and result structs, destination codes, register indexes, queue sizing
// no dependencies
package efsc_pkg;

    localparam int SYM_W     = 9;
    localparam int BYTE_W    = 8;
    localparam int DEST_W    = 2;
    localparam int CFG_IDX_W = 2;

    // result queue sizing
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [DEST_W-1:0] DEST_PAYLOAD = 2'd0;
    localparam logic [DEST_W-1:0] DEST_LINE    = 2'd1;
    localparam logic [DEST_W-1:0] DEST_OPENED  = 2'd2;
    localparam logic [DEST_W-1:0] DEST_CLOSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PING  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PONG  = 2'd3;

    localparam logic [SYM_W-1:0] START_RESET = 9'd257;
    localparam logic [SYM_W-1:0] END_RESET   = 9'd258;
    localparam logic [SYM_W-1:0] PING_RESET  = 9'd259;
    localparam logic [SYM_W-1:0] PONG_RESET  = 9'd260;

    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h00;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] rx_byte;
        logic [SYM_W-1:0]  tx_symbol;
    } in_item_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_item_t;

    // zero to two results produced by one item
    typedef struct packed {
        logic [1:0] count;
        out_item_t  r0;
        out_item_t  r1;
    } efsc_burst_t;

    typedef struct packed {
        logic [SYM_W-1:0] start_code;
        logic [SYM_W-1:0] end_code;
        logic [SYM_W-1:0] ping_code;
        logic [SYM_W-1:0] pong_code;
    } efsc_cfg_t;

endpackage

[rtl/efsc_decode.sv]
// efsc_decode: input register, escape and frame state, symbol decode
// turns one item into up to two results per cycle while the result queue has room
// depends on efsc_pkg
module efsc_decode
    import efsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    input  efsc_cfg_t   cfg,
    input  logic        room,
    output logic        push,
    output efsc_burst_t burst
);

    logic     valid_reg;
    in_item_t item_reg;
    logic     esc_reg;
    logic     esc_next;
    logic     frame_reg;
    logic     frame_next;
    logic     advance;

    // escape a symbol onto the line: zero and control symbols go out as 00, low byte
    function automatic efsc_burst_t send_sym(input logic [SYM_W-1:0] s);
        efsc_burst_t b;
        b = '0;
        b.r0.dest = DEST_LINE;
        b.r1.dest = DEST_LINE;
        if (s[SYM_W-1] || s[BYTE_W-1:0] == ESC_BYTE)
        begin
            b.count   = 2'd2;
            b.r0.data = ESC_BYTE;
            b.r1.data = s[BYTE_W-1:0];
            b.r1.last = 1'b1;
        end
        else
        begin
            b.count   = 2'd1;
            b.r0.data = s[BYTE_W-1:0];
            b.r0.last = 1'b1;
        end
        return b;
    endfunction

    assign advance  = valid_reg && room;
    assign in_stall = valid_reg && !room;
    assign push     = advance;

    always_comb
    begin
        logic [SYM_W-1:0] sym;
        logic             take;
        sym        = '0;
        take       = 1'b0;
        esc_next   = esc_reg;
        frame_next = frame_reg;
        burst      = '0;
        if (item_reg.kind)
        begin
            burst = send_sym(item_reg.tx_symbol);
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            take     = 1'b1;
            sym      = (item_reg.rx_byte == ESC_BYTE) ? '0 : {1'b1, item_reg.rx_byte};
        end
        else if (item_reg.rx_byte == ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            take = 1'b1;
            sym  = {1'b0, item_reg.rx_byte};
        end

        if (take)
        begin
            if (!frame_reg)
            begin
                if (sym == cfg.start_code)
                begin
                    frame_next     = 1'b1;
                    burst.count    = 2'd1;
                    burst.r0.dest  = DEST_OPENED;
                    burst.r0.last  = 1'b1;
                end
                else if (sym == cfg.ping_code)
                begin
                    burst = send_sym(cfg.pong_code);
                end
            end
            else if (sym == cfg.end_code)
            begin
                frame_next    = 1'b0;
                burst.count   = 2'd1;
                burst.r0.dest = DEST_CLOSED;
                burst.r0.last = 1'b1;
            end
            else
            begin
                burst.count   = 2'd1;
                burst.r0.dest = DEST_PAYLOAD;
                burst.r0.data = sym[BYTE_W-1:0];
                burst.r0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            esc_reg   <= 1'b0;
            frame_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
            if (advance)
            begin
                esc_reg   <= esc_next;
                frame_reg <= frame_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    a_tx_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.kind) |=> (esc_reg == $past(esc_reg)
                                        && frame_reg == $past(frame_reg)))
        else $error("transmit item changed receive state");

    a_two_results_line: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && burst.count == 2'd2) |->
            (burst.r0.dest == DEST_LINE && burst.r1.dest == DEST_LINE
             && burst.r0.data == ESC_BYTE && burst.r1.last && !burst.r0.last))
        else $error("two-result burst is not an escaped line pair");

    a_escape_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !item_reg.kind && esc_reg) |=> !esc_reg)
        else $error("pending escape not cleared by received byte");

endmodule

[rtl/efsc_outq.sv]
// efsc_outq: four-entry result queue, takes up to two results per cycle
// when it has room for two, and sends one per transfer on the output channel
// depends on efsc_pkg
module efsc_outq
    import efsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  efsc_burst_t burst,
    output logic        room,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    out_item_t              mem_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0]  wr_ptr_next;
    logic [OUTQ_PTR_W-1:0]  rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0]  count_reg;
    logic [OUTQ_CNT_W-1:0]  count_next;
    logic [1:0]             push_n;
    logic                   pop;

    // room for a full burst regardless of what leaves this cycle
    assign room      = count_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign push_n    = push ? burst.count : 2'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(push_n);
        count_next  = count_reg + OUTQ_CNT_W'(push_n) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= burst.r0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 1'b1] <= burst.r1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> room)
        else $error("burst written without room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_n == 2'd0) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count wrong after transfer");

endmodule

[rtl/escaped_frame_serial_codec.sv]
// escaped_frame_serial_codec: top level, configuration registers and the
// decode stage feeding the result queue
// depends on efsc_pkg, efsc_decode, efsc_outq
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_stall   in_item (in_item_t)
//  out       source     out_valid / out_stall out_item (out_item_t)
//  cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// an item with one or no result is taken every cycle while out_stall is
// low; an item that escapes onto the line makes two results and the
// one-per-cycle output port sets the pace. items pass the input register,
// then the result queue. reset clears codes to defaults, escape and frame
// state and the queue. in_stall rises only when the input register holds
// an item and the result queue has no room for two more results.
module escaped_frame_serial_codec
    import efsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SYM_W-1:0]     cfg_data
);

    efsc_cfg_t   cfg_reg;
    efsc_burst_t burst;
    logic        room;
    logic        push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code <= START_RESET;
            cfg_reg.end_code   <= END_RESET;
            cfg_reg.ping_code  <= PING_RESET;
            cfg_reg.pong_code  <= PONG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START: cfg_reg.start_code <= cfg_data;
                CFG_END:   cfg_reg.end_code   <= cfg_data;
                CFG_PING:  cfg_reg.ping_code  <= cfg_data;
                CFG_PONG:  cfg_reg.pong_code  <= cfg_data;
                default:   cfg_reg            <= cfg_reg;
            endcase
        end
    end

    efsc_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .room     (room),
        .push     (push),
        .burst    (burst)
    );

    efsc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .burst     (burst),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

[sim/testbench.sv]
// testbench for escaped_frame_serial_codec: directed and random traffic with a
// built-in escape/deframe predictor, per-field result checks and random stalls
// depends on efsc_pkg and the rtl of escaped_frame_serial_codec
module testbench;
    import efsc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int SETTLE_WAIT  = 8;
    localparam int REPORT_LIMIT = 10;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START;
    logic [SYM_W-1:0]     cfg_data  = '0;

    // predictor state
    efsc_cfg_t   codes;
    logic        esc_seen;
    logic        framed;
    out_item_t   due_results [$];
    int          burst_len;

    logic        idle_on = 1'b1;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned settings_used;
    int unsigned cycles;

    escaped_frame_serial_codec i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     due_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall = idle_on && ($urandom_range(0, 99) < 25);
    end

    // ---------------- predictor ----------------

    task automatic add_result(input logic [DEST_W-1:0] dest, input logic [BYTE_W-1:0] data);
        out_item_t r;
        r.dest = dest;
        r.data = data;
        r.last = 1'b0;
        due_results.push_back(r);
        burst_len++;
    endtask

    task automatic escape_to_line(input logic [SYM_W-1:0] sym);
        if (sym == '0 || sym[SYM_W-1])
        begin
            add_result(DEST_LINE, ESC_BYTE);
        end
        add_result(DEST_LINE, sym[BYTE_W-1:0]);
    endtask

    task automatic deframe(input logic [SYM_W-1:0] sym);
        if (!framed)
        begin
            // start wins over ping when both codes match
            if (sym == codes.start_code)
            begin
                framed = 1'b1;
                add_result(DEST_OPENED, '0);
            end
            else if (sym == codes.ping_code)
            begin
                escape_to_line(codes.pong_code);
            end
        end
        else if (sym == codes.end_code)
        begin
            framed = 1'b0;
            add_result(DEST_CLOSED, '0);
        end
        else
        begin
            add_result(DEST_PAYLOAD, sym[BYTE_W-1:0]);
        end
    endtask

    task automatic predict_item(input in_item_t it);
        out_item_t tail;
        burst_len = 0;
        if (it.kind)
        begin
            escape_to_line(it.tx_symbol);
        end
        else if (esc_seen)
        begin
            esc_seen = 1'b0;
            deframe((it.rx_byte == ESC_BYTE) ? SYM_W'(0) : {1'b1, it.rx_byte});
        end
        else if (it.rx_byte == ESC_BYTE)
        begin
            esc_seen = 1'b1;
        end
        else
        begin
            deframe({1'b0, it.rx_byte});
        end
        if (burst_len > 0)
        begin
            tail = due_results.pop_back();
            tail.last = 1'b1;
            due_results.push_back(tail);
        end
    endtask

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result %0d: dest %0d data %02h last %0b",
                             results_seen, out_item.dest, out_item.data, out_item.last);
            end
            else
            begin
                want = due_results.pop_front();
                if (out_item.dest !== want.dest || out_item.data !== want.data ||
                    out_item.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                                 results_seen, want.dest, want.data, want.last,
                                 out_item.dest, out_item.data, out_item.last);
                end
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_item(input in_item_t it);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 25)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        predict_item(it);
    endtask

    task automatic send_rx(input logic [BYTE_W-1:0] b);
        in_item_t it;
        it.kind      = 1'b0;
        it.rx_byte   = b;
        it.tx_symbol = SYM_W'($urandom_range(0, 511));
        send_item(it);
    endtask

    task automatic send_tx(input logic [SYM_W-1:0] sym);
        in_item_t it;
        it.kind      = 1'b1;
        it.rx_byte   = BYTE_W'($urandom_range(0, 255));
        it.tx_symbol = sym;
        send_item(it);
    endtask

    // line encoding of a decoded symbol, sometimes with a transfer to send
    // slipped in between the escape and its partner
    task automatic send_rx_symbol(input logic [SYM_W-1:0] sym);
        if (sym == '0 || sym[SYM_W-1])
        begin
            send_rx(ESC_BYTE);
            if ($urandom_range(0, 9) == 0)
                send_tx(SYM_W'($urandom_range(0, 511)));
        end
        send_rx(sym[BYTE_W-1:0]);
    endtask

    // wait until the block is idle
    task automatic quiesce();
        @(negedge clk);
        in_valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [SYM_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_START: codes.start_code = val;
            CFG_END:   codes.end_code   = val;
            CFG_PING:  codes.ping_code  = val;
            CFG_PONG:  codes.pong_code  = val;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_codes(input logic [SYM_W-1:0] start_sym, input logic [SYM_W-1:0] end_sym,
                             input logic [SYM_W-1:0] ping_sym, input logic [SYM_W-1:0] pong_sym);
        quiesce();
        write_code(CFG_START, start_sym);
        write_code(CFG_END, end_sym);
        write_code(CFG_PING, ping_sym);
        write_code(CFG_PONG, pong_sym);
        settings_used++;
    endtask

    function automatic logic [SYM_W-1:0] pick_code();
        case ($urandom_range(0, 7))
            0:       return SYM_W'(0);
            1:       return SYM_W'(511);
            2:       return SYM_W'(256);
            3:       return SYM_W'(255);
            4:       return SYM_W'($urandom_range(1, 255));
            default: return SYM_W'($urandom_range(257, 511));
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_default_codes();
        send_rx(ESC_BYTE);
        send_rx(8'h03);          // ping answered with escaped pong
        send_rx(8'h55);          // dropped while idle
        send_rx(ESC_BYTE);
        send_rx(8'h01);          // frame opened
        send_rx(8'hff);
        send_rx(ESC_BYTE);
        send_rx(ESC_BYTE);       // literal zero payload
        send_rx(ESC_BYTE);
        send_tx(SYM_W'(511));    // transmit while escape pending
        send_rx(8'h01);          // start inside frame is payload
        send_tx(SYM_W'(0));
        send_tx(SYM_W'(1));
        send_tx(SYM_W'(255));
        send_tx(SYM_W'(256));
        send_rx(ESC_BYTE);
        send_rx(8'h02);          // frame closed
    endtask

    task automatic test_code_overlap();
        // start equals ping, end is a plain byte, pong is zero
        set_codes(SYM_W'(8'h41), SYM_W'(255), SYM_W'(8'h41), SYM_W'(0));
        send_rx(8'h41);
        send_rx(8'h41);
        send_rx(8'hff);
        // start code that no decoding produces, ping at the top
        set_codes(SYM_W'(256), SYM_W'(0), SYM_W'(511), SYM_W'(255));
        send_rx(ESC_BYTE);
        send_rx(ESC_BYTE);
        send_rx(ESC_BYTE);
        send_rx(8'hff);
        quiesce();
        write_code(CFG_START, SYM_W'(0));
        send_rx(ESC_BYTE);
        send_rx(ESC_BYTE);
        send_rx(ESC_BYTE);
        send_rx(ESC_BYTE);
    endtask

    task automatic send_frame(input bit with_end);
        int len;
        len = $urandom_range(0, 8);
        send_rx_symbol(codes.start_code);
        repeat (len)
        begin
            if ($urandom_range(0, 4) == 0)
                send_rx_symbol(SYM_W'($urandom_range(257, 511)));
            else
                send_rx_symbol(SYM_W'($urandom_range(0, 255)));
        end
        if (with_end)
            send_rx_symbol(codes.end_code);
    endtask

    task automatic test_random_traffic();
        int unsigned phase_start;
        int pick;
        for (int p = 0; p < PHASES; p++)
        begin
            set_codes(pick_code(), pick_code(), pick_code(), pick_code());
            // a long stretch with neither side idling
            idle_on     = (p != 3 && p != 4);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_frame(1'b1);
                else if (pick < 62)
                    send_rx_symbol(codes.ping_code);
                else if (pick < 74)
                    send_tx(SYM_W'($urandom_range(0, 511)));
                else if (pick < 86)
                    send_rx(BYTE_W'($urandom_range(0, 255)));
                else if (pick < 93)
                    send_frame(1'b0);
                else
                begin
                    send_rx(ESC_BYTE);
                    send_rx(BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        codes.start_code = START_RESET;
        codes.end_code   = END_RESET;
        codes.ping_code  = PING_RESET;
        codes.pong_code  = PONG_RESET;
        esc_seen         = 1'b0;
        framed           = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_codes();
        test_code_overlap();
        test_random_traffic();
        quiesce();

        $display("ran %0d input transfers through %0d code settings, %0d results checked",
                 items_sent, settings_used + 1, results_seen);
        $display("%0d mismatches, %0d results never arrived", mismatches, due_results.size());
        if (mismatches == 0 && due_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
